/* rtl/prime_field_montgomery_alu_defines.svh */
// Assertion helpers for the prime-field ALU.
`ifndef PRIME_FIELD_MONTGOMERY_ALU_DEFINES_SVH
`define PRIME_FIELD_MONTGOMERY_ALU_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PFM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold after a delay of dly from the antecedent.
`define PFM_ASSERT_DELAY(lbl, ante, dly, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##dly (cons)) \
      else $error(msg);

`endif

/* rtl/pfm_alu_pkg.sv */
package pfm_alu_pkg;

   localparam int LIMB_W          = 64;
   localparam int LIMBS           = 4;
   localparam int WORD_W          = LIMB_W * LIMBS;
   localparam int STEPS_PER_ROUND = 8;
   localparam int NSTEP           = STEPS_PER_ROUND * LIMBS;
   // accept edge to the edge after the result strobe cycle
   localparam int LATENCY         = NSTEP + 3;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_FROM_MONT
   } op_type;

   typedef enum logic [2:0] {
      CSR_MOD_W0,
      CSR_MOD_W1,
      CSR_MOD_W2,
      CSR_MOD_W3,
      CSR_MONT_FACTOR
   } csr_index_type;

   typedef struct packed {
      logic                vld;
      op_type              op;
      logic [WORD_W-1:0]   a;
      logic [WORD_W-1:0]   b;
      logic [WORD_W-1:0]   r;
      logic [WORD_W+64:0]  t;
      logic [63:0]         m;
      logic [15:0][63:0]   pp;
      logic [3:0][127:0]   pr;
   } slot_type;

   function automatic logic [63:0] mul32(input logic [31:0] u, input logic [31:0] v);
      mul32 = 64'(u) * 64'(v);
   endfunction

   // One step of a CIOS round; the step code picks the work done.
   function automatic slot_type step_fn(input slot_type s, input logic [2:0] step,
                                        input logic [1:0] rnd,
                                        input logic [WORD_W-1:0] p,
                                        input logic [63:0] mf);
      slot_type          n;
      logic [63:0]       x;
      logic [63:0]       y;
      logic [WORD_W+64:0] acc;
      logic              is_mul;
      n      = s;
      x      = '0;
      y      = '0;
      acc    = '0;
      is_mul = (s.op == OP_MUL) || (s.op == OP_FROM_MONT);
      case (step) inside
         3'd0, 3'd5: begin
            // split limb products into 32x32 partials
            y = (step == 3'd0) ? s.b[64*rnd +: 64] : s.m;
            for (int j = 0; j < LIMBS; j++) begin
               x = (step == 3'd0) ? s.a[64*j +: 64] : p[64*j +: 64];
               n.pp[4*j+0] = mul32(x[31:0],  y[31:0]);
               n.pp[4*j+1] = mul32(x[31:0],  y[63:32]);
               n.pp[4*j+2] = mul32(x[63:32], y[31:0]);
               n.pp[4*j+3] = mul32(x[63:32], y[63:32]);
            end
         end
         3'd1, 3'd6: begin
            for (int j = 0; j < LIMBS; j++) begin
               n.pr[j] = 128'(s.pp[4*j+0]) + (128'(s.pp[4*j+1]) << 32)
                       + (128'(s.pp[4*j+2]) << 32) + (128'(s.pp[4*j+3]) << 64);
            end
         end
         3'd2: begin
            acc = (WORD_W+65)'(s.r);
            for (int j = 0; j < LIMBS; j++) begin
               acc = acc + ((WORD_W+65)'(s.pr[j]) << (64*j));
            end
            n.t = acc;
         end
         3'd3: begin
            // only the low word of the reduction factor is needed
            n.pp[0] = mul32(s.t[31:0],  mf[31:0]);
            n.pp[1] = mul32(s.t[31:0],  mf[63:32]);
            n.pp[2] = mul32(s.t[63:32], mf[31:0]);
         end
         3'd4: begin
            n.m = s.pp[0] + {s.pp[1][31:0], 32'b0} + {s.pp[2][31:0], 32'b0};
         end
         default: begin
            acc = s.t;
            for (int j = 0; j < LIMBS; j++) begin
               acc = acc + ((WORD_W+65)'(s.pr[j]) << (64*j));
            end
            // drop the low word; bits from 2^320 up are lost
            if (is_mul) begin
               n.r = acc[WORD_W+63:64];
            end
         end
      endcase
      step_fn = n;
   endfunction

endpackage

/* rtl/prime_field_montgomery_alu.sv */
// Channel   | ports                                   | handshake
// ----------+-----------------------------------------+---------------------------
// request   | req_type, req_a_w0..3, req_b_w0..3      | start & !busy
// response  | rsp_res_w0..3                           | rsp_valid, one cycle, no stall
// csr write | csr_index, csr_wdata                    | csr_valid & csr_ready
//
// One request enters per clock; busy is high only during reset.
// The result passes four CIOS rounds of eight register steps each (32x32 partial
// products, limb sums, factor, modulus products, accumulate), plus an entry, a
// prepare and a final stage, before it strobes on rsp_valid.
// Reset clears the pipeline valid bits and the modulus and factor registers.
// The receiver cannot stall; responses leave in request order.
`include "prime_field_montgomery_alu_defines.svh"

module prime_field_montgomery_alu
   import pfm_alu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [1:0]   req_type,
   input  logic [63:0]  req_a_w0,
   input  logic [63:0]  req_a_w1,
   input  logic [63:0]  req_a_w2,
   input  logic [63:0]  req_a_w3,
   input  logic [63:0]  req_b_w0,
   input  logic [63:0]  req_b_w1,
   input  logic [63:0]  req_b_w2,
   input  logic [63:0]  req_b_w3,
   output logic         rsp_valid,
   output logic [63:0]  rsp_res_w0,
   output logic [63:0]  rsp_res_w1,
   output logic [63:0]  rsp_res_w2,
   output logic [63:0]  rsp_res_w3,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_wdata
);

   logic [WORD_W-1:0] modulus_ff;
   logic [63:0]       mont_factor_ff;

   slot_type          entry_ff;
   slot_type          entry_in;
   slot_type          stage_ff [0:NSTEP];
   slot_type          prep_in;
   slot_type          last_slot;

   logic              rsp_valid_ff;
   logic [WORD_W-1:0] rsp_res_ff;
   logic [WORD_W-1:0] res_in;
   logic [WORD_W-1:0] sum_ab;
   logic [WORD_W-1:0] sum_ap;
   logic [WORD_W-1:0] fin_y;
   logic              fin_sub;

   assign busy      = reset;
   assign csr_ready = 1'b1;

   // Write the modulus limbs and the Montgomery factor.
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff     <= '0;
         mont_factor_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_MOD_W0:      modulus_ff[63:0]    <= csr_wdata;
            CSR_MOD_W1:      modulus_ff[127:64]  <= csr_wdata;
            CSR_MOD_W2:      modulus_ff[191:128] <= csr_wdata;
            CSR_MOD_W3:      modulus_ff[255:192] <= csr_wdata;
            CSR_MONT_FACTOR: mont_factor_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Capture the request; conversion out of Montgomery form multiplies by one.
   always_comb begin
      entry_in     = '0;
      entry_in.vld = start && !busy;
      entry_in.op  = op_type'(req_type);
      entry_in.a   = {req_a_w3, req_a_w2, req_a_w1, req_a_w0};
      entry_in.b   = (entry_in.op == OP_FROM_MONT) ? WORD_W'(1)
                                                   : {req_b_w3, req_b_w2, req_b_w1, req_b_w0};
   end

   // busy follows reset, so the entry valid bit is already low during reset.
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   // Prepare: add takes a + b, subtract takes a or a + p, multiply starts at zero.
   always_comb begin
      sum_ab = entry_ff.a + entry_ff.b;
      sum_ap = entry_ff.a + modulus_ff;
      prep_in = entry_ff;
      prep_in.vld = entry_ff.vld && !reset;
      case (entry_ff.op)
         OP_ADD:  prep_in.r = sum_ab;
         OP_SUB:  prep_in.r = (entry_ff.a < entry_ff.b) ? sum_ap : entry_ff.a;
         default: prep_in.r = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      stage_ff[0] <= prep_in;
   end

   // Advance through the CIOS rounds; add and subtract ride along untouched.
   for (genvar s = 0; s < NSTEP; s++) begin : g_step
      localparam int STEP = s % STEPS_PER_ROUND;
      localparam int RND  = s / STEPS_PER_ROUND;
      slot_type step_in;
      always_comb begin
         step_in     = step_fn(stage_ff[s], 3'(STEP), 2'(RND), modulus_ff,
                               mont_factor_ff);
         step_in.vld = stage_ff[s].vld && !reset;
      end
      always_ff @(posedge clock) begin
         stage_ff[s+1] <= step_in;
      end
   end

   // Final: subtract b for subtract, otherwise subtract p once when at or above p.
   always_comb begin
      last_slot = stage_ff[NSTEP];
      fin_sub   = (last_slot.op == OP_SUB) || (last_slot.r >= modulus_ff);
      fin_y     = (last_slot.op == OP_SUB) ? last_slot.b : modulus_ff;
      res_in    = fin_sub ? (last_slot.r - fin_y) : last_slot.r;
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= res_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= last_slot.vld;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_res_w0 = rsp_res_ff[63:0];
   assign rsp_res_w1 = rsp_res_ff[127:64];
   assign rsp_res_w2 = rsp_res_ff[191:128];
   assign rsp_res_w3 = rsp_res_ff[255:192];

   `PFM_ASSERT_DELAY(a_req_to_rsp, start && !busy, LATENCY, rsp_valid, "request produced no response")
   `PFM_ASSERT_NOW(a_rsp_has_req, rsp_valid, $past(start && !busy, LATENCY), "response without request")
   `PFM_ASSERT_DELAY(a_idle_in_idle_out, !(start && !busy), LATENCY, !rsp_valid, "spurious response")

endmodule
